>>> rtl/cltok_pkg.sv
// Shared types, constants and helpers for the CSV line field tokenizer.
// No dependencies; the top level and the output register import this package.
package cltok_pkg;

    localparam int MaxFieldDef = 32;

    localparam logic [7:0] QuoteChar = 8'h22;
    localparam logic [7:0] CommaChar = 8'h2C;
    localparam logic [7:0] SpaceChar = 8'h20;

    // configuration register indexes
    localparam logic CfgSep  = 1'b0;
    localparam logic CfgTrim = 1'b1;

    typedef enum logic [1:0] {
        M_IDLE,
        M_PLAIN,
        M_QUOTED,
        M_AFTER
    } t_mode;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_EMIT,
        S_MARK,
        S_LINE
    } t_state;

    typedef struct packed {
        logic [7:0] out_char;
        logic       is_char;
        logic       field_end;
        logic       line_end;
        logic       unterminated;
        logic       overflow;
        logic       last;
    } t_result;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D)) ||
               (c == 8'h85) || (c == 8'hA0);
    endfunction

endpackage

>>> rtl/csv_line_field_tokenizer_unit.sv
// CSV line field tokenizer, top level: parse FSM, field buffer, emit sequencer.
// A field's first character beat follows the taking of its closing character through a
// buffer read, then an emit into the output register; a lone marker needs no buffer read.
// Each kept character takes a buffer read and an emit, a folded whitespace character a
// read with no beat, and each inserted space and marker an emit alone.
// Throughput: one character per cycle while a field fills; the input is held while a
// field is sent, through the read-then-emit sequence, and longer under any output stall.
// Reset (synchronous, active low): parser idle, field empty, separator comma, trim off.
module csv_line_field_tokenizer_unit #(
    parameter int MAX_FIELD = cltok_pkg::MaxFieldDef
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_ch,
    input  logic       i_line_last,
    // configuration writes
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    // result channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_char,
    output logic       o_is_char,
    output logic       o_field_end,
    output logic       o_line_end,
    output logic       o_unterminated,
    output logic       o_overflow,
    output logic       o_last
);
    import cltok_pkg::*;

    localparam int LW = $clog2(MAX_FIELD + 1);  // holds a length 0..MAX_FIELD
    localparam int AW = $clog2(MAX_FIELD);      // buffer address

    // configuration
    logic [7:0] r_sep;
    logic       r_trim_en;

    // parser state, updated once per accepted beat
    t_mode         r_mode, n_mode;
    logic [LW-1:0] r_len, n_len;      // characters kept in the buffer
    logic [LW-1:0] r_tlen, n_tlen;    // length up to the last non-whitespace
    logic          r_fovf, n_fovf;    // characters dropped on a full buffer

    // emit sequencer
    t_state        r_state, n_state;
    logic [LW-1:0] r_idx, n_idx;
    logic [LW-1:0] r_end, n_end;
    logic          r_simp, n_simp;
    logic          r_gap, n_gap;
    logic          r_movf, n_movf;    // overflow flag for the field-end marker
    logic          r_line, n_line;    // line-end marker follows the field
    logic          r_unt, n_unt;

    // buffer ports
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_re;
    logic [7:0]    mem_rdata;

    // output register
    logic    oreg_load;
    t_result oreg_res;
    logic    oreg_free;

    // parse decode
    logic          in_acc;
    logic          is_q, is_sep, c_ws;
    logic          restart, wr, send, use_trim;
    t_mode         m1;
    logic [LW-1:0] base_len, base_tlen, len_new, tlen_new, end_sel;
    logic          base_ovf, ovf_new;
    logic          eol_send, eol_simp, any_send, unt_new;
    logic [LW-1:0] idx_inc;

    assign o_stall = (r_state != S_IDLE);
    assign in_acc  = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sep     <= CommaChar;
            r_trim_en <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgSep:  r_sep     <= i_cfg_data;
                CfgTrim: r_trim_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Decode the accepted character into buffer write, field send and mode change.
    always_comb begin
        is_q     = (i_ch == QuoteChar);
        is_sep   = (i_ch == r_sep);
        c_ws     = is_ws(i_ch);
        restart  = 1'b0;
        wr       = 1'b0;
        send     = 1'b0;
        use_trim = 1'b0;
        m1       = r_mode;

        // at field start, quote wins over separator, separator over whitespace
        unique case (r_mode)
            M_IDLE: begin
                priority if (is_q) begin
                    restart = 1'b1;
                    m1      = M_QUOTED;
                end else if (is_sep) begin
                    restart = 1'b1;
                    send    = 1'b1;
                end else if (!c_ws) begin
                    restart = 1'b1;
                    wr      = 1'b1;
                    m1      = M_PLAIN;
                end else begin
                    // leading whitespace: skip it
                end
            end
            M_PLAIN: begin
                if (is_sep) begin
                    send     = 1'b1;
                    use_trim = 1'b1;
                    m1       = M_IDLE;
                end else begin
                    wr = 1'b1;
                end
            end
            M_QUOTED: begin
                if (is_q) begin
                    send = 1'b1;
                    m1   = M_AFTER;
                end else begin
                    wr = 1'b1;
                end
            end
            M_AFTER: begin
                if (is_sep) begin
                    m1 = M_IDLE;
                end
            end
            default: ;
        endcase

        base_len  = restart ? '0 : r_len;
        base_tlen = restart ? '0 : r_tlen;
        base_ovf  = restart ? 1'b0 : r_fovf;
        len_new   = base_len;
        tlen_new  = base_tlen;
        ovf_new   = base_ovf;
        mem_we    = 1'b0;
        mem_waddr = base_len[AW-1:0];

        // store the character, or drop it on a full buffer
        if (wr) begin
            if (base_len < LW'(MAX_FIELD)) begin
                mem_we  = in_acc;
                len_new = base_len + LW'(1);
                if (!c_ws) begin
                    tlen_new = base_len + LW'(1);
                end
            end else begin
                ovf_new = 1'b1;
            end
        end

        // line end: flush a pending plain field, drop a pending quoted one
        eol_send = i_line_last && (m1 == M_PLAIN);
        eol_simp = eol_send && r_trim_en;
        unt_new  = i_line_last && (m1 == M_QUOTED);
        any_send = send || eol_send;
        end_sel  = (use_trim || eol_simp) ? tlen_new : len_new;
    end

    // Sequencer: next state, buffer reads and result beats.
    always_comb begin
        n_mode    = r_mode;
        n_len     = r_len;
        n_tlen    = r_tlen;
        n_fovf    = r_fovf;
        n_state   = r_state;
        n_idx     = r_idx;
        n_end     = r_end;
        n_simp    = r_simp;
        n_gap     = r_gap;
        n_movf    = r_movf;
        n_line    = r_line;
        n_unt     = r_unt;
        mem_re    = 1'b0;
        oreg_load = 1'b0;
        oreg_res  = '0;
        idx_inc   = r_idx + LW'(1);

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mode = i_line_last ? M_IDLE : m1;
                    if (any_send || i_line_last) begin
                        n_len  = '0;
                        n_tlen = '0;
                        n_fovf = 1'b0;
                    end else begin
                        n_len  = len_new;
                        n_tlen = tlen_new;
                        n_fovf = ovf_new;
                    end
                    n_idx  = '0;
                    n_end  = end_sel;
                    n_simp = eol_simp;
                    n_gap  = 1'b0;
                    n_movf = ovf_new;
                    n_line = i_line_last;
                    n_unt  = unt_new;
                    if (any_send) begin
                        n_state = (end_sel == '0) ? S_MARK : S_RD;
                    end else if (i_line_last) begin
                        n_state = S_LINE;
                    end
                end
            end
            S_RD: begin
                mem_re  = 1'b1;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (oreg_free) begin
                    priority if (r_simp && is_ws(mem_rdata)) begin
                        // fold whitespace into a pending gap
                        n_gap   = 1'b1;
                        n_idx   = idx_inc;
                        n_state = (idx_inc == r_end) ? S_MARK : S_RD;
                    end else if (r_simp && r_gap) begin
                        // one space for the gap, hold the character
                        oreg_load        = 1'b1;
                        oreg_res.out_char = SpaceChar;
                        oreg_res.is_char = 1'b1;
                        n_gap            = 1'b0;
                    end else begin
                        oreg_load        = 1'b1;
                        oreg_res.out_char = mem_rdata;
                        oreg_res.is_char = 1'b1;
                        n_idx            = idx_inc;
                        n_state          = (idx_inc == r_end) ? S_MARK : S_RD;
                    end
                end
            end
            S_MARK: begin
                if (oreg_free) begin
                    oreg_load          = 1'b1;
                    oreg_res.field_end = 1'b1;
                    oreg_res.overflow  = r_movf;
                    oreg_res.last      = !r_line;
                    n_state            = r_line ? S_LINE : S_IDLE;
                end
            end
            S_LINE: begin
                if (oreg_free) begin
                    oreg_load             = 1'b1;
                    oreg_res.line_end     = 1'b1;
                    oreg_res.unterminated = r_unt;
                    oreg_res.last         = 1'b1;
                    n_state               = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_len   <= '0;
            r_tlen  <= '0;
            r_fovf  <= 1'b0;
            r_state <= S_IDLE;
        end else begin
            r_mode  <= n_mode;
            r_len   <= n_len;
            r_tlen  <= n_tlen;
            r_fovf  <= n_fovf;
            r_state <= n_state;
        end
    end

    // per-field payload, meaningful only while the sequencer is busy
    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_end  <= n_end;
        r_simp <= n_simp;
        r_gap  <= n_gap;
        r_movf <= n_movf;
        r_line <= n_line;
        r_unt  <= n_unt;
    end

    cltok_fbuf #(
        .DEPTH (MAX_FIELD),
        .AW    (AW)
    ) u_fbuf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_ch),
        .i_re    (mem_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    cltok_oreg u_oreg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (oreg_load),
        .i_res          (oreg_res),
        .o_free         (oreg_free),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_char     (o_out_char),
        .o_is_char      (o_is_char),
        .o_field_end    (o_field_end),
        .o_line_end     (o_line_end),
        .o_unterminated (o_unterminated),
        .o_overflow     (o_overflow),
        .o_last         (o_last)
    );

`ifndef SYNTH
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len <= LW'(MAX_FIELD)) && (r_tlen <= r_len))
        else $error("field length out of range");

    a_idx_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_EMIT)) |-> (r_idx < r_end))
        else $error("buffer read past field end");

    a_eol_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_line_last) |=> ((r_mode == M_IDLE) && (r_len == '0)))
        else $error("parser not reset at line end");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (r_state == S_IDLE))
        else $error("buffer written while a field is sent");
`endif

endmodule

>>> rtl/cltok_fbuf.sv
// Field character buffer: one write port, one read port, registered read data.
// Depends on nothing; sized by the top level.
module cltok_fbuf #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cltok_oreg.sv
// Output register for result beats; decouples the emitter from downstream stall.
// Depends on cltok_pkg for the result struct.
module cltok_oreg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  cltok_pkg::t_result  i_res,
    output logic                o_free,
    input  logic                i_stall,
    output logic                o_valid,
    output logic [7:0]          o_out_char,
    output logic                o_is_char,
    output logic                o_field_end,
    output logic                o_line_end,
    output logic                o_unterminated,
    output logic                o_overflow,
    output logic                o_last
);
    import cltok_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid        = r_valid;
    assign o_out_char     = r_res.out_char;
    assign o_is_char      = r_res.is_char;
    assign o_field_end    = r_res.field_end;
    assign o_line_end     = r_res.line_end;
    assign o_unterminated = r_res.unterminated;
    assign o_overflow     = r_res.overflow;
    assign o_last         = r_res.last;

endmodule

>>> tb/tb_top.sv
// Self-checking bench for csv_line_field_tokenizer_unit: drives characters, lines and
// register writes, predicts every output beat in a local model and compares in order.
// Depends only on cltok_pkg and the tokenizer RTL.
module tb_top;
    import cltok_pkg::*;

    localparam int MAX_FIELD     = MaxFieldDef;
    localparam int CYCLE_LIMIT   = 500000;
    // quiet cycles after the last expected beat
    localparam int SETTLE_CYCLES = 40;
    localparam logic [7:0] SEMICOLON = 8'h3B;

    // flush styles of a finished field
    typedef enum {
        FLUSH_RAW,
        FLUSH_TRIM,
        FLUSH_SIMPLIFY
    } t_flush;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_ch;
    logic       i_line_last;
    logic       i_cfg_we;
    logic       i_cfg_idx;
    logic [7:0] i_cfg_data;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_out_char;
    logic       o_is_char;
    logic       o_field_end;
    logic       o_line_end;
    logic       o_unterminated;
    logic       o_overflow;
    logic       o_last;

    // local copy of the tokenizer state and registers
    t_mode      pmode;
    logic [7:0] field_chars [MAX_FIELD];
    int         flen;
    logic       field_ovf;
    logic [7:0] sep_reg;
    logic       trim_reg;

    t_result    step_beats[$];     // beats caused by the character being predicted
    t_result    pending_beats[$];  // beats predicted but not yet seen on the output
    t_result    want_beat;
    logic [7:0] line_buf[$];       // characters of the line about to be sent

    int         tx_gap_pct;
    int         rx_stall_pct;
    int         rx_hold_left;
    int         chars_sent;
    int         mismatch_count;
    int         cycle_count;

    csv_line_field_tokenizer_unit #(
        .MAX_FIELD(MAX_FIELD)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .i_line_last    (i_line_last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_char     (o_out_char),
        .o_is_char      (o_is_char),
        .o_field_end    (o_field_end),
        .o_line_end     (o_line_end),
        .o_unterminated (o_unterminated),
        .o_overflow     (o_overflow),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Whitespace as the tokenizer sees it: the C0 controls TAB..CR, space, NEL, NBSP.
    function automatic logic is_blank(input logic [7:0] c);
        case (c)
            8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20, 8'h85, 8'hA0: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic void add_beat(input logic [7:0] c, input logic isc, input logic fe,
                                     input logic le, input logic unt, input logic ovf);
        t_result b;
        b.out_char     = c;
        b.is_char      = isc;
        b.field_end    = fe;
        b.line_end     = le;
        b.unterminated = unt;
        b.overflow     = ovf;
        b.last         = 1'b0;
        step_beats.push_back(b);
    endfunction

    // Keep a character while there is room; past capacity only remember the loss.
    function automatic void keep_char(input logic [7:0] c);
        if (flen < MAX_FIELD) begin
            field_chars[flen] = c;
            flen++;
        end else begin
            field_ovf = 1'b1;
        end
    endfunction

    function automatic void flush_field(input t_flush how);
        int         stop;
        logic       gap;
        logic [7:0] c;
        stop = flen;
        gap  = 1'b0;
        if (how == FLUSH_TRIM) begin
            while (stop > 0 && is_blank(field_chars[stop - 1])) stop--;
        end
        for (int i = 0; i < stop; i++) begin
            c = field_chars[i];
            // simplified: drop every blank, put one space where a run stood inside
            if (how == FLUSH_SIMPLIFY && is_blank(c)) begin
                gap = 1'b1;
                continue;
            end
            if (gap) add_beat(SpaceChar, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
            gap = 1'b0;
            add_beat(c, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        end
        add_beat(8'h00, 1'b0, 1'b1, 1'b0, 1'b0, field_ovf);
        flen      = 0;
        field_ovf = 1'b0;
    endfunction

    // Advance the local tokenizer by one accepted character and queue its beats.
    function automatic void tokenize_char(input logic [7:0] c, input logic eol);
        t_result tail;
        logic    unt;
        step_beats.delete();
        case (pmode)
            M_IDLE: begin
                // quote wins over separator, separator wins over whitespace
                if (c == QuoteChar) begin
                    flen      = 0;
                    field_ovf = 1'b0;
                    pmode     = M_QUOTED;
                end else if (c == sep_reg) begin
                    flen      = 0;
                    field_ovf = 1'b0;
                    flush_field(FLUSH_RAW);
                end else if (!is_blank(c)) begin
                    flen      = 0;
                    field_ovf = 1'b0;
                    keep_char(c);
                    pmode     = M_PLAIN;
                end
            end
            M_PLAIN: begin
                if (c == sep_reg) begin
                    flush_field(FLUSH_TRIM);
                    pmode = M_IDLE;
                end else begin
                    keep_char(c);
                end
            end
            M_QUOTED: begin
                if (c == QuoteChar) begin
                    flush_field(FLUSH_RAW);
                    pmode = M_AFTER;
                end else begin
                    keep_char(c);
                end
            end
            default: begin
                // after a closing quote everything up to the separator is dropped
                if (c == sep_reg) pmode = M_IDLE;
            end
        endcase
        if (eol) begin
            unt = 1'b0;
            if (pmode == M_QUOTED) unt = 1'b1;
            else if (pmode == M_PLAIN) flush_field(trim_reg ? FLUSH_SIMPLIFY : FLUSH_RAW);
            add_beat(8'h00, 1'b0, 1'b0, 1'b1, unt, 1'b0);
            pmode     = M_IDLE;
            flen      = 0;
            field_ovf = 1'b0;
        end
        if (step_beats.size() != 0) begin
            tail      = step_beats.pop_back();
            tail.last = 1'b1;
            step_beats.push_back(tail);
        end
        foreach (step_beats[i]) pending_beats.push_back(step_beats[i]);
    endfunction

    // ------------------------------------------------------------------
    // Checking: compare each accepted output beat with the oldest prediction
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        // treat an unknown valid as a beat so that it cannot slip through
        if (i_rst_n && !i_stall && o_valid !== 1'b0) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected beat: out_char %0h is_char %0b field_end %0b line_end %0b",
                       o_out_char, o_is_char, o_field_end, o_line_end);
                mismatch_count++;
            end else begin
                want_beat = pending_beats.pop_front();
                check_field("out_char", want_beat.out_char, o_out_char);
                check_field("is_char", 8'(want_beat.is_char), 8'(o_is_char));
                check_field("field_end", 8'(want_beat.field_end), 8'(o_field_end));
                check_field("line_end", 8'(want_beat.line_end), 8'(o_line_end));
                check_field("unterminated", 8'(want_beat.unterminated), 8'(o_unterminated));
                check_field("overflow", 8'(want_beat.overflow), 8'(o_overflow));
                check_field("last", 8'(want_beat.last), 8'(o_last));
            end
        end
    end

    // Watchdog: end the run if the traffic never drains.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: a long hold-off when one is requested, random stalls otherwise.
    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            i_stall <= 1'b1;
            rx_hold_left--;
        end else begin
            i_stall <= ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one character beat; predict it at the edge where it is taken.
    task automatic send_char(input logic [7:0] c, input logic eol);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            // idle cycle: drop valid and scramble the payload, which must be ignored
            i_valid     <= 1'b0;
            i_ch        <= 8'($urandom);
            i_line_last <= 1'($urandom);
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_ch        <= c;
        i_line_last <= eol;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tokenize_char(c, eol);
        chars_sent++;
    endtask

    // Send the buffered line, flagging its last character as the end of the line.
    task automatic send_line();
        foreach (line_buf[i]) send_char(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    // Drop valid, wait for every predicted beat, then let the block settle.
    task automatic wait_for_drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        i_cfg_data <= 8'($urandom);
        if (idx == CfgSep) sep_reg = data;
        else trim_reg = data[0];
    endtask

    // Set both registers; junk in the unused trim bits must be ignored.
    task automatic configure(input logic [7:0] sep, input logic trim);
        write_reg(CfgSep, sep);
        write_reg(CfgTrim, {7'($urandom), trim});
    endtask

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 7))
            0: return 8'h09;
            1: return 8'h0A;
            2: return 8'h0B;
            3: return 8'h0C;
            4: return 8'h0D;
            5: return 8'h20;
            6: return 8'h85;
            default: return 8'hA0;
        endcase
    endfunction

    // Mostly letters and digits, some blanks, some arbitrary bytes.
    function automatic logic [7:0] text_char(input logic allow_sep, input logic allow_quote);
        logic [7:0] c;
        int         pick;
        do begin
            pick = $urandom_range(0, 9);
            if (pick < 4) c = 8'h61 + 8'($urandom_range(0, 25));
            else if (pick < 6) c = 8'h30 + 8'($urandom_range(0, 9));
            else if (pick < 8) c = blank_char();
            else c = 8'($urandom);
        end while ((!allow_sep && c == sep_reg) || (!allow_quote && c == QuoteChar));
        return c;
    endfunction

    // First character of a plain field: not blank, not a quote, not the separator.
    function automatic logic [7:0] lead_char();
        logic [7:0] c;
        do c = text_char(1'b0, 1'b0); while (is_blank(c));
        return c;
    endfunction

    function automatic void add_blanks(input int count);
        logic [7:0] c;
        repeat (count) begin
            c = blank_char();
            if (c != sep_reg) line_buf.push_back(c);
        end
    endfunction

    // Build one line of mostly well-formed fields with some noise mixed in.
    function automatic void build_random_line();
        int n_fields;
        int kind;
        n_fields = $urandom_range(1, 4);
        for (int f = 0; f < n_fields; f++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                add_blanks($urandom_range(0, 2));
                line_buf.push_back(lead_char());
                repeat ($urandom_range(0, 7)) line_buf.push_back(text_char(1'b0, 1'b1));
                add_blanks($urandom_range(0, 2));
            end else if (kind < 66) begin
                add_blanks($urandom_range(0, 1));
                line_buf.push_back(QuoteChar);
                repeat ($urandom_range(0, 8)) line_buf.push_back(text_char(1'b1, 1'b0));
                // leave the last quoted field open now and then
                if (f != n_fields - 1 || $urandom_range(0, 99) >= 15) begin
                    line_buf.push_back(QuoteChar);
                    repeat ($urandom_range(0, 1)) line_buf.push_back(text_char(1'b0, 1'b1));
                end
            end else if (kind < 80) begin
                // empty field: the separator alone
            end else if (kind < 84) begin
                line_buf.push_back(lead_char());
                repeat ($urandom_range(32, 36)) line_buf.push_back(text_char(1'b0, 1'b1));
            end else begin
                repeat ($urandom_range(1, 4)) line_buf.push_back(8'($urandom));
            end
            if (f != n_fields - 1) line_buf.push_back(sep_reg);
        end
        if ($urandom_range(0, 9) == 0) line_buf.push_back(sep_reg);
        if (line_buf.size() == 0) line_buf.push_back(sep_reg);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lone separator line, blank skipping and trimming, unterminated quote.
    task automatic test_empty_and_blank_fields();
        line_buf = '{CommaChar};
        send_line();
        line_buf = '{8'h20, "a", "b", 8'h20, CommaChar, QuoteChar, "x"};
        send_line();
    endtask

    // Separator inside quotes, junk after the closing quote, raw last field.
    task automatic test_quoted_fields();
        line_buf = '{QuoteChar, CommaChar, QuoteChar, "z", CommaChar, 8'hFF, 8'h20};
        send_line();
    endtask

    // Simplified last field: a run of mixed blanks collapses, trailing blanks go.
    task automatic test_trim_last();
        wait_for_drain();
        write_reg(CfgTrim, 8'hFF);
        line_buf = '{8'h00, "a", 8'h85, 8'hA0, "b", 8'h0D, 8'h20};
        send_line();
    endtask

    task automatic test_random_lines(input int n_items);
        int start;
        start = chars_sent;
        while (chars_sent - start < n_items) begin
            build_random_line();
            send_line();
        end
    endtask

    // Fields past capacity in every flush style, plus one exactly at capacity.
    task automatic test_field_overflow();
        wait_for_drain();
        configure(CommaChar, 1'b1);
        line_buf.push_back(lead_char());
        repeat ($urandom_range(32, 34)) line_buf.push_back(text_char(1'b0, 1'b1));
        send_line();
        line_buf.push_back(QuoteChar);
        repeat (33) line_buf.push_back(text_char(1'b1, 1'b0));
        line_buf.push_back(QuoteChar);
        line_buf.push_back(CommaChar);
        line_buf.push_back(lead_char());
        repeat (33) line_buf.push_back(text_char(1'b0, 1'b1));
        add_blanks(2);
        line_buf.push_back(CommaChar);
        send_line();
        line_buf.push_back(lead_char());
        repeat (MAX_FIELD - 1) line_buf.push_back(text_char(1'b0, 1'b1));
        send_line();
    endtask

    // Hold the output off for a long stretch while characters keep coming,
    // so a field send cannot finish and the input stalls.
    task automatic test_output_backpressure();
        wait_for_drain();
        configure(SEMICOLON, 1'b1);
        set_idling(0, 0);
        rx_hold_left = 400;
        test_random_lines(40);
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_ch           = 8'h00;
        i_line_last    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CfgSep;
        i_cfg_data     = 8'h00;
        i_stall        = 1'b0;
        tx_gap_pct     = 0;
        rx_stall_pct   = 0;
        rx_hold_left   = 0;
        chars_sent     = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        sep_reg        = CommaChar;
        trim_reg       = 1'b0;
        pmode          = M_IDLE;
        flen           = 0;
        field_ovf      = 1'b0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sender sparse gaps, receiver stalls often
        set_idling(23, 59);
        test_empty_and_blank_fields();
        test_quoted_fields();
        test_trim_last();
        wait_for_drain();
        configure(CommaChar, 1'b0);
        test_random_lines(40);
        test_field_overflow();
        wait_for_drain();
        configure(QuoteChar, 1'b1);
        test_random_lines(35);

        // sender gaps often, receiver stalls rarely; blank and extreme separators
        set_idling(59, 23);
        wait_for_drain();
        configure(8'h20, 1'b0);
        test_random_lines(35);
        wait_for_drain();
        configure(8'h00, 1'b1);
        test_random_lines(35);
        test_output_backpressure();

        // full rate both ways
        set_idling(0, 0);
        wait_for_drain();
        configure(8'hFF, 1'b0);
        test_random_lines(35);
        wait_for_drain();
        configure(CommaChar, 1'b1);
        test_random_lines(35);
        wait_for_drain();

        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/cltok_pkg.sv
rtl/cltok_fbuf.sv
rtl/cltok_oreg.sv
rtl/csv_line_field_tokenizer_unit.sv
tb/tb_top.sv
